### hw/rtl/sha_pkg.sv
package sha_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } eng_state_e;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### hw/rtl/sha256_message_hasher_unit.sv
// sha-256 byte-stream hasher
// input channel: in_valid_i/in_ready_o with data_byte_i, byte_valid_i, last_byte_i
// output channel: out_valid_o/out_ready_i with digest_word_o, word_index_o, last_word_o
// a 4-entry queue takes transactions while the compression engine is busy
// a byte that completes a 64-byte block starts a compression in the engine
// (one round per cycle in the shared round unit); other bytes do not
// a last transaction pads and runs one or two compressions; the first digest
// word is valid once the result of the last compression is added into the hash
// then eight digest words, word 0 first, last_word_o on word 7, one per cycle when
// out_ready_i is high and held while it is low; the engine waits and the queue fills
// reset clears the queue and restores the initial hash values
module sha256_message_hasher_unit import sha_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item = '{data: data_byte_i, vld: byte_valid_i, last: last_byte_i};

  sha_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  sha_engine u_engine (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o, .out_ready_i, .digest_word_o, .word_index_o, .last_word_o
  );

`ifndef SYNTH
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word mismatch");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=> out_valid_o &&
    word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest index skipped");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !q_ready)
    else $error("engine took item while emitting");
`endif
endmodule

### hw/rtl/sha_fifo.sv
module sha_fifo import sha_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);
  localparam int Aw = $clog2(Depth);
  item_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != (Aw+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule

### hw/rtl/sha_engine.sv
module sha_engine import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  eng_state_e state_q, state_d;
  logic [5:0]  fill_q;
  logic [63:0] bits_q, total_q;
  logic [31:0] h_q [8];
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        fin_q;
  logic        pad2_q;
  logic        pad_done_q;
  logic        emit_v_q;

  logic take;
  logic [31:0] w_cur, t1, t2, s0, s1, wn;
  logic [31:0] pad_win [16];
  logic [63:0] total_d;

  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = s1 + w_q[9] + s0 + w_q[0];
    w_cur = w_q[0];
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + w_cur;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // padded copy of the block window
  always_comb begin
    total_d = bits_q + {55'd0, fill_q, 3'd0};
    for (int i = 0; i < 16; i++) begin
      pad_win[i] = w_q[i];
      for (int k = 0; k < 4; k++) begin
        if (6'(4*i+k) == fill_q) pad_win[i][31-8*k -: 8] = 8'h80;
        else if (6'(4*i+k) > fill_q) pad_win[i][31-8*k -: 8] = 8'h00;
      end
    end
    if (fill_q < 6'd56) begin
      pad_win[14] = total_d[63:32];
      pad_win[15] = total_d[31:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign take = in_valid_i & in_ready_o;
  assign out_valid_o = emit_v_q;
  assign digest_word_o = h_q[idx_q];
  assign word_index_o = idx_q;
  assign last_word_o = (idx_q == 3'd7);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (in_item_i.vld && fill_q == 6'd63) state_d = ST_LOAD;
          else if (in_item_i.last) state_d = ST_PAD;
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (!fin_q) state_d = ST_IDLE;
        else if (!pad_done_q) state_d = ST_PAD;
        else if (pad2_q) state_d = ST_LOAD;
        else state_d = ST_EMIT;
      end
      ST_PAD:   state_d = ST_LOAD;
      ST_EMIT:  if (out_ready_i && idx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      total_q <= '0;
      fin_q <= 1'b0;
      pad2_q <= 1'b0;
      pad_done_q <= 1'b0;
      idx_q <= '0;
      emit_v_q <= 1'b0;
      rnd_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            fin_q <= in_item_i.last;
            if (in_item_i.vld) fill_q <= fill_q + 1'b1;
            if (in_item_i.vld && fill_q == 6'd63) bits_q <= bits_q + 64'd512;
          end
        end
        ST_PAD: begin
          total_q <= total_d;
          pad2_q <= (fill_q >= 6'd56);
          pad_done_q <= 1'b1;
        end
        ST_LOAD: rnd_q <= '0;
        ST_ROUND: rnd_q <= rnd_q + 1'b1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (fin_q && pad_done_q && pad2_q) pad2_q <= 1'b0;
          if (fin_q && pad_done_q && !pad2_q) begin
            emit_v_q <= 1'b1;
            idx_q <= '0;
          end
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == 3'd7) begin
              emit_v_q <= 1'b0;
              fin_q <= 1'b0;
              pad_done_q <= 1'b0;
              fill_q <= '0;
              bits_q <= '0;
              for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (take && in_item_i.vld)
          w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_item_i.data;
      end
      ST_PAD: begin
        for (int i = 0; i < 16; i++) w_q[i] <= pad_win[i];
      end
      ST_ADD: begin
        if (fin_q && pad_done_q && pad2_q) begin
          for (int i = 0; i < 14; i++) w_q[i] <= '0;
          w_q[14] <= total_q[63:32];
          w_q[15] <= total_q[31:0];
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= (rnd_q < 6'd48) ? wn : w_q[0];
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
      default: ;
    endcase
  end
endmodule

### tb/sha256_message_hasher_unit_tb.sv
`timescale 1ns / 100ps

module sha256_message_hasher_unit_tb import sha_pkg::*; ();

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_txn_t;

  localparam int CycleLimit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  logic [7:0]  msg_block [64];
  int unsigned msg_fill;
  logic [63:0] msg_bits;
  logic [31:0] chain_hash [8];
  digest_txn_t pending_digests [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          stall_enable = 1'b1;
  bit          in_gaps = 1'b1;

  sha256_message_hasher_unit dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_model();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
  endtask

  task automatic restart_model();
    msg_fill = 0;
    msg_bits = '0;
    for (int i = 0; i < 8; i++) chain_hash[i] = H_INIT[i];
  endtask

  task automatic predict_hash(logic [7:0] b, logic bv, logic lb);
    logic [63:0] total;
    digest_txn_t d;
    if (bv) begin
      msg_block[msg_fill] = b;
      msg_fill++;
      if (msg_fill == 64) begin
        compress_model();
        msg_bits += 64'd512;
        msg_fill = 0;
      end
    end
    if (!lb) return;
    total = msg_bits + 64'(msg_fill * 8);
    msg_block[msg_fill] = 8'h80;
    for (int i = msg_fill + 1; i < 64; i++) msg_block[i] = '0;
    if (msg_fill >= 56) begin
      compress_model();
      for (int i = 0; i < 56; i++) msg_block[i] = '0;
    end
    for (int i = 0; i < 8; i++) msg_block[63-i] = total[8*i +: 8];
    compress_model();
    for (int i = 0; i < 8; i++) begin
      d.word = chain_hash[i];
      d.index = 3'(i);
      d.last = (i == 7);
      pending_digests.push_back(d);
    end
    restart_model();
  endtask

  task automatic send_byte(logic [7:0] b, logic bv, logic lb);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    byte_valid_i <= bv;
    last_byte_i <= lb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_hash(b, bv, lb);
  endtask

  task automatic send_message(int len, bit empty_end);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), 1'b1, (!empty_end && i == len - 1));
    if (empty_end || len == 0) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h62, 1'b1, 1'b0);
    send_byte(8'h63, 1'b1, 1'b1);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'haa, 1'b1, 1'b1);
  endtask

  task automatic test_block_edges();
    send_message(56, 1'b0);
    send_message(63, 1'b0);
    send_message(64, 1'b0);
    send_message(64, 1'b1);
  endtask

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 90) begin
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1,
                  (i == len - 1) && $urandom_range(0, 1));
        if (msg_fill == 0 && msg_bits == 0 && i == len - 1) len = 0;
        sent++;
      end
      if (msg_fill != 0 || msg_bits != 0 || len == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  task automatic test_no_idling();
    in_gaps = 1'b0;
    stall_enable = 1'b0;
    send_message(70, 1'b0);
    send_message(3, 1'b1);
    send_message(20, 1'b0);
  endtask

  always @(posedge clk_i) begin
    digest_txn_t exp_d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_digests.size() == 0) begin
        $error("unexpected digest transaction word=%h", digest_word_o);
        error_count++;
      end else begin
        exp_d = pending_digests.pop_front();
        if (digest_word_o !== exp_d.word) begin
          $error("digest_word expected %h actual %h", exp_d.word, digest_word_o);
          error_count++;
        end
        if (word_index_o !== exp_d.index) begin
          $error("word_index expected %0d actual %0d", exp_d.index, word_index_o);
          error_count++;
        end
        if (last_word_o !== exp_d.last) begin
          $error("last_word expected %0d actual %0d", exp_d.last, last_word_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!stall_enable) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sha256_message_hasher_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    restart_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_edges();
    test_random_messages();
    test_no_idling();
    in_valid_i <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && pending_digests.size() == 0) begin
      $display("sha256_message_hasher_unit_tb: clean");
    end else begin
      $display("sha256_message_hasher_unit_tb: errors");
    end
    $finish;
  end

endmodule
